// ===== design/sact_pkg.sv =====
package sact_pkg;

   localparam int ADDR_W  = 32;
   localparam int CNT_W   = 32;
   localparam int STAMP_W = 32;
   localparam int OFS_W   = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS    = 1'b1;

   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [3:0]       way;
      logic             evicted;
      logic [CNT_W-1:0] read_hit_count;
      logic [CNT_W-1:0] read_miss_count;
      logic [CNT_W-1:0] write_hit_count;
      logic [CNT_W-1:0] write_miss_count;
   } rsp_type;

   // Classified access handed from the front end to the back end.
   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] block;
   } acc_type;

endpackage

// ===== design/set_assoc_cache_tag_lookup_unit.sv =====
// Channel   | Ports                              | Handshake
// request   | start, busy, req_data              | taken when start && !busy
// response  | rsp_valid, rsp_data                | one-cycle strobe, no stall
// config    | csr_we, csr_index, csr_data        | written when csr_we
//
// Requests go through the back end one at a time: queue pop, set read from the
// per-way tag RAMs, then compare, victim choice and write-back; the response
// strobe comes in the next cycle.
// Reset is synchronous and clears valid bits, counters and the access clock.
// The front end holds busy while the two-entry queue is full; the response
// side cannot stall.
module set_assoc_cache_tag_lookup_unit #(
   parameter int NUM_SETS = 64,
   parameter int WAYS     = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  sact_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output sact_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [sact_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sact_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Configuration registers.
   logic                       policy_ff, policy_in;
   logic [sact_pkg::OFS_W-1:0] offset_ff, offset_in;

   always_comb begin
      policy_in = policy_ff;
      offset_in = offset_ff;
      if (csr_we) begin
         unique case (csr_index)
            sact_pkg::CSR_REPLACE_POLICY: policy_in = csr_data[0];
            sact_pkg::CSR_OFFSET_BITS:    offset_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= sact_pkg::POLICY_LRU;
         offset_ff <= '0;
      end else begin
         policy_ff <= policy_in;
         offset_ff <= offset_in;
      end
   end

   // Two-entry queue between the front end and the back end.
   sact_pkg::acc_type q_mem_ff [2];
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic       q_wp_ff, q_wp_in, q_rp_ff, q_rp_in;
   logic       q_push, q_pop, q_full, q_valid;
   sact_pkg::acc_type push_data;

   assign q_full  = (q_cnt_ff == 2'd2);
   assign q_valid = (q_cnt_ff != 2'd0);

   always_comb begin
      q_wp_in  = q_wp_ff ^ q_push;
      q_rp_in  = q_rp_ff ^ q_pop;
      q_cnt_in = q_cnt_ff + {1'b0, q_push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         q_wp_ff  <= 1'b0;
         q_rp_ff  <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         q_wp_ff  <= q_wp_in;
         q_rp_ff  <= q_rp_in;
      end
      if (q_push) begin
         q_mem_ff[q_wp_ff] <= push_data;
      end
   end

   sact_front u_front (
      .start      (start),
      .req_data   (req_data),
      .offset_bits(offset_ff),
      .q_full     (q_full),
      .busy       (busy),
      .q_push     (q_push),
      .q_data     (push_data)
   );

   sact_back #(.NUM_SETS(NUM_SETS), .WAYS(WAYS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .replace_policy(policy_ff),
      .q_valid       (q_valid),
      .q_data        (q_mem_ff[q_rp_ff]),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue underflow");
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> !rsp_data.evicted) else $error("hit evicted");
`endif

endmodule

// ===== design/sact_ram.sv =====
module sact_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/sact_front.sv =====
module sact_front (
   input  logic                       start,
   input  sact_pkg::req_type          req_data,
   input  logic [sact_pkg::OFS_W-1:0] offset_bits,
   input  logic                       q_full,
   output logic                       busy,
   output logic                       q_push,
   output sact_pkg::acc_type          q_data
);

   // Busy while the queue cannot take another access.
   assign busy   = q_full;
   assign q_push = start && !q_full;

   always_comb begin
      q_data.cmd   = req_data.cmd;
      q_data.block = req_data.address >> offset_bits;
   end

endmodule

// ===== design/sact_back.sv =====
module sact_back #(
   parameter int NUM_SETS = 64,
   parameter int WAYS     = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              replace_policy,
   input  logic              q_valid,
   input  sact_pkg::acc_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   output sact_pkg::rsp_type rsp_data
);

   localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int LINE_W = sact_pkg::ADDR_W + 2 * sact_pkg::STAMP_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0] state_ff, state_in;
   sact_pkg::acc_type acc_ff, acc_in;
   logic [sact_pkg::STAMP_W-1:0] clock_ff, clock_in;
   logic [sact_pkg::CNT_W-1:0] cnt_ff [4];
   logic [sact_pkg::CNT_W-1:0] cnt_in [4];
   logic [NUM_SETS*WAYS-1:0] valid_ff, valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   sact_pkg::rsp_type rsp_ff, rsp_in;

   logic [SET_W-1:0] set_idx;
   logic [WAYS-1:0]  we;
   logic [LINE_W-1:0] rd_line [WAYS];
   logic [LINE_W-1:0] wr_line;

   if (NUM_SETS > 1) begin : g_set
      assign set_idx = acc_ff.block[SET_W-1:0];
   end else begin : g_noset
      assign set_idx = '0;
   end

   for (genvar w = 0; w < WAYS; w++) begin : g_way
      sact_ram #(.WIDTH(LINE_W), .DEPTH(NUM_SETS)) u_ram (
         .clock  (clock),
         .wr_en  (we[w]),
         .wr_addr(set_idx),
         .wr_data(wr_line),
         .rd_addr(set_idx),
         .rd_data(rd_line[w])
      );
   end

   logic [sact_pkg::STAMP_W-1:0] stamp;
   logic hit, free_found;
   logic [3:0] hit_way, free_way, vic_way, sel_way;
   logic [sact_pkg::STAMP_W-1:0] least, cand, hit_load;
   logic [1:0] slot;
   logic vbit;

   always_comb begin
      stamp      = clock_ff + 1'b1;
      hit        = 1'b0;
      hit_way    = '0;
      hit_load   = '0;
      free_found = 1'b0;
      free_way   = '0;
      vic_way    = '0;
      least      = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         vbit = valid_ff[int'(set_idx) * WAYS + w];
         if (vbit && rd_line[w][LINE_W-1 -: sact_pkg::ADDR_W] == acc_ff.block) begin
            hit      = 1'b1;
            hit_way  = 4'(w);
            hit_load = rd_line[w][sact_pkg::STAMP_W-1:0];
         end
         if (!vbit) begin
            free_found = 1'b1;
            free_way   = 4'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         cand = (replace_policy == sact_pkg::POLICY_FIFO) ?
                rd_line[w][sact_pkg::STAMP_W-1:0] :
                rd_line[w][2*sact_pkg::STAMP_W-1 -: sact_pkg::STAMP_W];
         if (w == 0 || cand < least) begin
            least   = cand;
            vic_way = 4'(w);
         end
      end
      sel_way = hit ? hit_way : (free_found ? free_way : vic_way);
      slot    = {acc_ff.cmd, !hit};
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      clock_in     = clock_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      we           = '0;
      wr_line      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               acc_in   = q_data;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            clock_in = stamp;
            for (int w = 0; w < WAYS; w++) begin
               we[w] = (sel_way == 4'(w));
            end
            if (hit) begin
               wr_line = {acc_ff.block, stamp, hit_load};
            end else begin
               wr_line = {acc_ff.block, stamp, stamp};
            end
            valid_in[int'(set_idx) * WAYS + int'(sel_way)] = 1'b1;
            cnt_in[slot] = cnt_ff[slot] + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in.hit              = hit;
            rsp_in.way              = sel_way;
            rsp_in.evicted          = !hit && !free_found;
            rsp_in.read_hit_count   = cnt_in[0];
            rsp_in.read_miss_count  = cnt_in[1];
            rsp_in.write_hit_count  = cnt_in[2];
            rsp_in.write_miss_count = cnt_in[3];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ff     <= '0;
         cnt_ff       <= '{default: '0};
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/set_assoc_cache_tag_lookup_unit_checker.sv =====
`timescale 1ns / 1ps
module set_assoc_cache_tag_lookup_unit_checker #(
   parameter int NUM_SETS = 64,
   parameter int WAYS     = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  sact_pkg::req_type                 req_data,
   input  logic                              rsp_valid,
   input  sact_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [sact_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sact_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                fail_count,
   output int                                pending
);
   import sact_pkg::*;

   localparam int LINES = NUM_SETS * WAYS;

   logic             policy;
   logic [OFS_W-1:0] shift;
   logic             valid_q [LINES];
   logic [31:0]      tag_q [LINES];
   logic [31:0]      used_at [LINES];
   logic [31:0]      loaded_at [LINES];
   logic [31:0]      access_clock;
   logic [31:0]      tally [4];
   rsp_type          lookups_due [$];

   assign pending = lookups_due.size();

   function automatic rsp_type lookup(input req_type r);
      rsp_type     o;
      logic [31:0] blk;
      int          base;
      int          w;
      int          way;
      logic        found;
      logic        free;
      logic [31:0] least;
      blk = r.address >> shift;
      base = int'(blk % NUM_SETS) * WAYS;
      found = 1'b0;
      free = 1'b0;
      way = 0;
      o = '0;
      access_clock = access_clock + 1;
      for (w = 0; w < WAYS; w++)
         if (!found && valid_q[base+w] && tag_q[base+w] == blk) begin
            found = 1'b1;
            way = w;
         end
      if (found) begin
         used_at[base+way] = access_clock;
      end else begin
         for (w = 0; w < WAYS; w++)
            if (!free && !valid_q[base+w]) begin
               free = 1'b1;
               way = w;
            end
         if (!free) begin
            // Oldest stamp wins; strict compare keeps the lowest way on ties.
            least = (policy == POLICY_FIFO) ? loaded_at[base] : used_at[base];
            for (w = 1; w < WAYS; w++) begin
               if (policy == POLICY_FIFO && loaded_at[base+w] < least) begin
                  least = loaded_at[base+w];
                  way = w;
               end
               if (policy == POLICY_LRU && used_at[base+w] < least) begin
                  least = used_at[base+w];
                  way = w;
               end
            end
            o.evicted = 1'b1;
         end
         valid_q[base+way] = 1'b1;
         tag_q[base+way] = blk;
         used_at[base+way] = access_clock;
         loaded_at[base+way] = access_clock;
      end
      tally[{r.cmd, ~found}] = tally[{r.cmd, ~found}] + 1;
      o.hit = found;
      o.way = way[3:0];
      o.read_hit_count = tally[0];
      o.read_miss_count = tally[1];
      o.write_hit_count = tally[2];
      o.write_miss_count = tally[3];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         policy = POLICY_LRU;
         shift = '0;
         for (int i = 0; i < LINES; i++) begin
            valid_q[i] = 1'b0;
            tag_q[i] = '0;
            used_at[i] = '0;
            loaded_at[i] = '0;
         end
         access_clock = '0;
         for (int i = 0; i < 4; i++) tally[i] = '0;
         lookups_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_REPLACE_POLICY) policy = csr_data[0];
            else if (csr_index == CSR_OFFSET_BITS) shift = csr_data;
         end
         if (start && !busy) lookups_due.push_back(lookup(req_data));
         if (rsp_valid) begin
            if (lookups_due.size() == 0) begin
               if (fail_count < 10) $display("response with no request pending");
               fail_count <= fail_count + 1;
            end else begin
               want = lookups_due.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: exp hit=%0d way=%0d ev=%0d cnt=%0d/%0d/%0d/%0d, got hit=%0d way=%0d ev=%0d cnt=%0d/%0d/%0d/%0d",
                              want.hit, want.way, want.evicted, want.read_hit_count,
                              want.read_miss_count, want.write_hit_count,
                              want.write_miss_count, rsp_data.hit, rsp_data.way,
                              rsp_data.evicted, rsp_data.read_hit_count,
                              rsp_data.read_miss_count, rsp_data.write_hit_count,
                              rsp_data.write_miss_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/sv/set_assoc_cache_tag_lookup_unit_tb.sv =====
`timescale 1ns / 1ps
module set_assoc_cache_tag_lookup_unit_tb;
   import sact_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending;
   int                    cycle_count = 0;
   int                    idle_pct;
   logic [31:0]           hot_tags [8];

   set_assoc_cache_tag_lookup_unit dut (.*);

   set_assoc_cache_tag_lookup_unit_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The run is bounded: the 821 requests fit well inside this limit even with
   // the sender idling.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Issue one request and hold start until the block takes it. Before the
   // request the sender may, at random, idle with start low. Start stays
   // high after the accepting edge; the next request or an explicit drop
   // replaces it.
   task automatic send_access(input logic cmd, input logic [31:0] addr);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{cmd: cmd, address: addr};
      do @(posedge clock); while (busy);
   endtask

   // Registers change only when the block is idle, so drain first and then
   // let the back end settle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly reuse a few hot blocks so that sets fill, hit and evict; the
   // rest is fully random traffic.
   task automatic random_phase(input int n, input logic [3:0] ofs);
      logic [31:0] a;
      for (int i = 0; i < 8; i++) hot_tags[i] = $urandom_range(7);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0) begin
            a = $urandom();
         end else begin
            // One of two sets, up to eight blocks in each, so a four-way set overflows.
            a = ((hot_tags[$urandom_range(7)] * 64 + $urandom_range(1)) << ofs)
                | ($urandom() & ((32'h1 << ofs) - 1));
         end
         send_access(1'($urandom_range(1)), a);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_pct = 27;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of the address, both commands, a set filling up
      // and spilling over under LRU, then a hit refreshing the access time.
      send_access(CMD_READ, 32'h0000_0000);
      send_access(CMD_WRITE, 32'hFFFF_FFFF);
      send_access(CMD_READ, 32'h0000_0000);
      for (int i = 1; i <= 5; i++) send_access(i[0], i * 64);
      send_access(CMD_WRITE, 32'h0000_0080);
      send_access(CMD_READ, 32'h0000_0400);
      send_access(CMD_READ, 32'hAAAA_AAAA);
      send_access(CMD_WRITE, 32'h5555_5555);

      // First in first out with the largest offset the field holds.
      write_csr(CSR_REPLACE_POLICY, 4'(POLICY_FIFO));
      write_csr(CSR_OFFSET_BITS, 4'd15);
      for (int i = 0; i < 6; i++) send_access(CMD_WRITE, i << 21);
      send_access(CMD_READ, 32'h0020_0000);
      write_csr(CSR_OFFSET_BITS, 4'd12);
      send_access(CMD_READ, 32'hFFFF_FFFF);
      send_access(CMD_WRITE, 32'h0000_0FFF);

      random_phase(250, 4'd12);
      write_csr(CSR_REPLACE_POLICY, 4'(POLICY_LRU));
      write_csr(CSR_OFFSET_BITS, 4'd0);
      idle_pct = 45;
      random_phase(250, 4'd0);
      write_csr(CSR_REPLACE_POLICY, 4'(POLICY_FIFO));
      write_csr(CSR_OFFSET_BITS, 4'd6);
      idle_pct = 0;
      random_phase(150, 4'd6);
      write_csr(CSR_REPLACE_POLICY, 4'(POLICY_LRU));
      write_csr(CSR_OFFSET_BITS, 4'd13);
      random_phase(150, 4'd13);
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
design/sact_pkg.sv
design/sact_ram.sv
design/sact_front.sv
design/sact_back.sv
design/set_assoc_cache_tag_lookup_unit.sv
tb/sv/set_assoc_cache_tag_lookup_unit_checker.sv
tb/sv/set_assoc_cache_tag_lookup_unit_tb.sv
